>>> rtl/core/ptbd_pkg.sv
// Shared types and register index codes for the point-to-box distance block.
package ptbd_pkg;

  // Configuration register index
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CORNER_X = 3'd0;
  localparam cfg_idx_t CFG_CORNER_Y = 3'd1;
  localparam cfg_idx_t CFG_CORNER_Z = 3'd2;
  localparam cfg_idx_t CFG_SIZE_X   = 3'd3;
  localparam cfg_idx_t CFG_SIZE_Y   = 3'd4;
  localparam cfg_idx_t CFG_SIZE_Z   = 3'd5;

endpackage

>>> rtl/core/point_to_box_distance_top.sv
// Top level of the point-to-box distance pipeline.
//
// Each input item is one 3-D point in signed Q8.8 (COORD_WIDTH bits per axis). The block
// returns the floored Euclidean distance to the configured axis-aligned box as unsigned
// Q9.8 in out_tdata, with out_tuser[0] set when the point lies within the box (faces
// included), in which case the distance is zero. One item is accepted every cycle unless a
// full stage holds behind a stalled output. The stages are one for the per-axis clamp, one
// for the squares, one for the sum, and COORD_WIDTH+1 square-root stages that each settle
// one result bit. Each stage has its own valid bit and holds only while the stage after it
// is full and stalled, so bubbles close up and the input keeps flowing while a result waits
// at the output. Box registers are written on the cfg port; the user must do so only while
// the block is idle, which the block itself does not enforce. All of them reset to zero.
module point_to_box_distance_top
  import ptbd_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Input items: tdata = point_x, point_y, point_z (from bit 0 up), zero padded
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  // Result items: tdata = distance (from bit 0 up), zero padded
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((COORD_WIDTH+8)/8)*8-1:0]         out_tdata,
  // tuser = inside_res
  output logic [0:0]                               out_tuser,
  // Configuration write port
  input  logic                                     cfg_we,
  input  cfg_idx_t                                 cfg_index,
  input  logic [COORD_WIDTH-1:0]                   cfg_wdata
);

  localparam int W      = COORD_WIDTH;
  localparam int OUT_DW = ((COORD_WIDTH + 8) / 8) * 8;
  localparam int NSQ    = W + 1;
  localparam int NS     = NSQ + 3;

  // Box registers
  logic signed [W-1:0] corner_x_r, corner_y_r, corner_z_r;
  logic        [W-2:0] size_x_r, size_y_r, size_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_x_r <= '0;
      corner_y_r <= '0;
      corner_z_r <= '0;
      size_x_r   <= '0;
      size_y_r   <= '0;
      size_z_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CORNER_X: corner_x_r <= cfg_wdata;
        CFG_CORNER_Y: corner_y_r <= cfg_wdata;
        CFG_CORNER_Z: corner_z_r <= cfg_wdata;
        CFG_SIZE_X:   size_x_r   <= cfg_wdata[W-2:0];
        CFG_SIZE_Y:   size_y_r   <= cfg_wdata[W-2:0];
        CFG_SIZE_Z:   size_z_r   <= cfg_wdata[W-2:0];
        default: begin
        end
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  assign adv[NS-1] = !vld_r[NS-1] || out_tready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_adv
    assign adv[i] = !vld_r[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_tready = adv[0];

  // Stage 1: clamp each axis
  logic signed [W-1:0] pt_x, pt_y, pt_z;
  logic [W-1:0] ex_nxt, ey_nxt, ez_nxt;
  logic [W-1:0] s1_ex_r, s1_ey_r, s1_ez_r;
  logic         s1_ins_r;

  assign pt_x = in_tdata[W-1:0];
  assign pt_y = in_tdata[2*W-1:W];
  assign pt_z = in_tdata[3*W-1:2*W];

  ptbd_excess #(.W(W)) u_ex_x (
    .point(pt_x), .corner(corner_x_r), .size(size_x_r), .excess(ex_nxt)
  );
  ptbd_excess #(.W(W)) u_ex_y (
    .point(pt_y), .corner(corner_y_r), .size(size_y_r), .excess(ey_nxt)
  );
  ptbd_excess #(.W(W)) u_ex_z (
    .point(pt_z), .corner(corner_z_r), .size(size_z_r), .excess(ez_nxt)
  );

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_ex_r  <= ex_nxt;
      s1_ey_r  <= ey_nxt;
      s1_ez_r  <= ez_nxt;
      s1_ins_r <= (ex_nxt == '0) && (ey_nxt == '0) && (ez_nxt == '0);
    end
  end

  // Stage 2: squares
  logic [2*W-1:0] sq_x_nxt, sq_y_nxt, sq_z_nxt;
  logic [2*W-1:0] s2_sq_x_r, s2_sq_y_r, s2_sq_z_r;
  logic           s2_ins_r;

  assign sq_x_nxt = s1_ex_r * s1_ex_r;
  assign sq_y_nxt = s1_ey_r * s1_ey_r;
  assign sq_z_nxt = s1_ez_r * s1_ez_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_sq_x_r <= sq_x_nxt;
      s2_sq_y_r <= sq_y_nxt;
      s2_sq_z_r <= sq_z_nxt;
      s2_ins_r  <= s1_ins_r;
    end
  end

  // Stage 3: sum of squares, two guard bits
  logic [2*W+1:0] sum_nxt;
  logic [2*W+1:0] s3_sum_r;
  logic           s3_ins_r;

  assign sum_nxt = {2'b00, s2_sq_x_r} + {2'b00, s2_sq_y_r} + {2'b00, s2_sq_z_r};

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_sum_r <= sum_nxt;
      s3_ins_r <= s2_ins_r;
    end
  end

  // Square-root stages, one result bit each
  logic [2*W+1:0] rad_r  [NSQ];
  logic [W+3:0]   rem_r  [NSQ];
  logic [W:0]     root_r [NSQ];
  logic           sq_ins_r [NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [2*W+1:0] rad_i, rad_nxt;
    logic [W+3:0]   rem_i, rem_nxt;
    logic [W:0]     root_i, root_nxt;
    logic           ins_i;

    if (k == 0) begin : g_first
      assign rad_i  = s3_sum_r;
      assign rem_i  = '0;
      assign root_i = '0;
      assign ins_i  = s3_ins_r;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign ins_i  = sq_ins_r[k-1];
    end

    ptbd_sqrt_step #(.W(W)) u_step (
      .rad_in(rad_i), .rem_in(rem_i), .root_in(root_i),
      .rad_out(rad_nxt), .rem_out(rem_nxt), .root_out(root_nxt)
    );

    always_ff @(posedge clk) begin
      if (adv[k+3]) begin
        rad_r[k]    <= rad_nxt;
        rem_r[k]    <= rem_nxt;
        root_r[k]   <= root_nxt;
        sq_ins_r[k] <= ins_i;
      end
    end
  end

  // Last square-root stage is the output register
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = OUT_DW'(root_r[NSQ-1]);
  assign out_tuser  = sq_ins_r[NSQ-1];

endmodule

>>> rtl/core/ptbd_excess.sv
// Per-axis excess: how far a point lies outside [corner, corner + size].
module ptbd_excess #(
  parameter int W = 16
) (
  input  logic signed [W-1:0] point,
  input  logic signed [W-1:0] corner,
  input  logic        [W-2:0] size,
  output logic        [W-1:0] excess
);

  logic signed [W:0] p_ext;
  logic signed [W:0] lo_ext;
  logic signed [W:0] hi_ext;
  logic        [W:0] below_diff;
  logic        [W:0] above_diff;

  // Upper bound carries one extra bit so it never wraps
  assign p_ext  = {point[W-1], point};
  assign lo_ext = {corner[W-1], corner};
  assign hi_ext = lo_ext + $signed({2'b00, size});

  assign below_diff = lo_ext - p_ext;
  assign above_diff = p_ext - hi_ext;

  // Distance to the clamp; both differences fit in W bits when taken
  always_comb begin
    if (p_ext < lo_ext) begin
      excess = below_diff[W-1:0];
    end else if (p_ext > hi_ext) begin
      excess = above_diff[W-1:0];
    end else begin
      excess = '0;
    end
  end

endmodule

>>> rtl/core/ptbd_sqrt_step.sv
// One digit step of the restoring square root: consumes two radicand bits.
module ptbd_sqrt_step #(
  parameter int W = 16
) (
  input  logic [2*W+1:0] rad_in,
  input  logic [W+3:0]   rem_in,
  input  logic [W:0]     root_in,
  output logic [2*W+1:0] rad_out,
  output logic [W+3:0]   rem_out,
  output logic [W:0]     root_out
);

  logic [W+3:0] rem_sh;
  logic [W+3:0] trial;
  logic         take;

  // Bring down the next two radicand bits and test 4*root + 1
  assign rem_sh = {rem_in[W+1:0], rad_in[2*W+1:2*W]};
  assign trial  = {1'b0, root_in, 2'b01};
  assign take   = (rem_sh >= trial);

  assign rem_out  = take ? (rem_sh - trial) : rem_sh;
  assign root_out = {root_in[W-1:0], take};
  assign rad_out  = {rad_in[2*W-1:0], 2'b00};

endmodule

>>> rtl/core/ptbd_checker.sv
// Port-level checks for the point-to-box distance block, bound to the top level.
module ptbd_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [((COORD_WIDTH+8)/8)*8-1:0]   out_tdata,
  input  logic [0:0]                         out_tuser
);

  localparam int W = COORD_WIDTH;

  // Nothing comes out of a pipeline just reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Inside means zero distance
  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[W:0] == '0)
    else $error("inside point with nonzero distance");

  // Outside is at least one LSB away, so the root is nonzero
  a_outside_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[W:0] != '0)
    else $error("outside point with zero distance");

  // Padding above the distance stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >> (W + 1)) == '0)
    else $error("nonzero padding in result");

endmodule

bind point_to_box_distance_top ptbd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ptbd_checker (
  .clk(clk), .rst_n(rst_n),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
